>>> rtl/q31_newton_raphson_divider_macros.svh
// Assertion macros shared by the Q31 Newton-Raphson divider RTL.
`ifndef Q31_NEWTON_RAPHSON_DIVIDER_MACROS_SVH
`define Q31_NEWTON_RAPHSON_DIVIDER_MACROS_SVH
`ifndef SYNTHESIS
`define Q31NR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("q31nr assertion failed");
`define Q31NR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("q31nr assertion failed");
`else
`define Q31NR_ASSERT_IMP(label, ante, cons)
`define Q31NR_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> rtl/q31nr_pkg.sv
// Types, constants and helper functions of the Q31 Newton-Raphson divider.
`default_nettype none
package q31nr_pkg;
  localparam int NEWTON_STEPS = 3;
  localparam int WORD_W = 32;
  localparam int FRAC_W = 30;

  localparam logic [28:0] COEF_8_17 = 29'd252645135;
  localparam logic [31:0] COEF_12_17 = 32'd378967702;
  localparam logic signed [35:0] Q29_ONE = 36'sd536870912;
  localparam logic signed [63:0] Q29_HALF = 64'sd268435456;
  localparam logic signed [67:0] Q29_HALF_W = 68'sd268435456;
  localparam logic signed [63:0] OUT_ROUND = 64'sd67108864;
  localparam logic signed [63:0] MAG_LIMIT = 64'sd2147483648;
  localparam logic [31:0] NORM_LIMIT = 32'h4000_0000;
  localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic zero;
    logic big;
    logic neg;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/q31nr_if.sv
// Valid/ready channel interfaces for operand pairs and quotients.
`default_nettype none
interface q31nr_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] numerator;
  logic signed [31:0] denominator;
  modport source (output valid, numerator, denominator, input ready);
  modport sink (input valid, numerator, denominator, output ready);
endinterface

interface q31nr_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] quotient;
  logic divide_by_zero;
  logic saturated;
  modport source (output valid, quotient, divide_by_zero, saturated, input ready);
  modport sink (input valid, quotient, divide_by_zero, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/q31nr_norm.sv
// Magnitude, special case detection and normalization stages.
`default_nettype none
module q31nr_norm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [31:0]  numerator_i,
  input  wire logic signed [31:0]  denominator_i,
  output q31nr_pkg::ctl_t          ctl_o,
  output logic [q31nr_pkg::FRAC_W-1:0] d_o,
  output logic [q31nr_pkg::FRAC_W-1:0] n_o
);
  q31nr_pkg::ctl_t ctl_a_q, ctl_a_d, ctl_b_q;
  logic [31:0] an_q, ad_q, an_d, ad_d;
  logic [q31nr_pkg::FRAC_W-1:0] d_q, n_q, d_d, n_d;
  logic [4:0] msb, lz, shamt;
  logic [31:0] ad_sh, an_sh;
  logic pow2;

  always_comb begin
    an_d = numerator_i[31] ? (~numerator_i + 32'd1) : numerator_i;
    ad_d = denominator_i[31] ? (~denominator_i + 32'd1) : denominator_i;
    ctl_a_d.valid = valid_i;
    ctl_a_d.zero = (denominator_i == 32'sd0);
    ctl_a_d.neg = (an_d != 32'd0) && (numerator_i[31] ^ denominator_i[31]);
    ctl_a_d.big = (an_d >= ad_d);
  end

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (ad_q[i]) begin
        msb = 5'(i);
      end
    end
    lz = 5'd31 - msb;
    pow2 = ((ad_q & (ad_q - 32'd1)) == 32'd0);
    if (ad_q > q31nr_pkg::NORM_LIMIT) begin
      shamt = 5'd0;
    end else if (pow2) begin
      shamt = lz;
    end else begin
      shamt = lz - 5'd1;
    end
    ad_sh = ad_q << shamt;
    an_sh = an_q << shamt;
    d_d = ad_sh[31:2];
    n_d = an_sh[31:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q <= an_d;
      ad_q <= ad_d;
      d_q <= d_d;
      n_q <= n_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign d_o = d_q;
  assign n_o = n_q;
endmodule
`default_nettype wire

>>> rtl/q31nr_seed.sv
// Reciprocal seed stages: X0 = 4 * (12/17 - 8/17 * D) in Q29.
`default_nettype none
module q31nr_seed (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire q31nr_pkg::ctl_t             ctl_i,
  input  wire logic [q31nr_pkg::FRAC_W-1:0] d_i,
  input  wire logic [q31nr_pkg::FRAC_W-1:0] n_i,
  output q31nr_pkg::ctl_t                  ctl_o,
  output logic [q31nr_pkg::FRAC_W-1:0]     d_o,
  output logic [q31nr_pkg::FRAC_W-1:0]     n_o,
  output logic signed [31:0]               x_o
);
  q31nr_pkg::ctl_t ctl_a_q, ctl_b_q;
  logic [q31nr_pkg::FRAC_W-1:0] d_a_q, n_a_q, d_b_q, n_b_q;
  logic [58:0] p_a_q, p_d;
  logic [58:0] p_rnd;
  logic [31:0] diff;
  logic signed [31:0] x_d, x_b_q;

  always_comb begin
    p_d = 59'(q31nr_pkg::COEF_8_17) * 59'(d_i);
    p_rnd = (p_a_q + 59'(q31nr_pkg::Q29_HALF)) >> 29;
    diff = q31nr_pkg::COEF_12_17 - p_rnd[31:0];
    x_d = $signed(diff << 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_a_q <= d_i;
      n_a_q <= n_i;
      p_a_q <= p_d;
      d_b_q <= d_a_q;
      n_b_q <= n_a_q;
      x_b_q <= x_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign d_o = d_b_q;
  assign n_o = n_b_q;
  assign x_o = x_b_q;
endmodule
`default_nettype wire

>>> rtl/q31nr_step.sv
// One Newton-Raphson refinement X += X * (1 - D * X) over two stages.
`default_nettype none
module q31nr_step (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire q31nr_pkg::ctl_t             ctl_i,
  input  wire logic [q31nr_pkg::FRAC_W-1:0] d_i,
  input  wire logic [q31nr_pkg::FRAC_W-1:0] n_i,
  input  wire logic signed [31:0]          x_i,
  output q31nr_pkg::ctl_t                  ctl_o,
  output logic [q31nr_pkg::FRAC_W-1:0]     d_o,
  output logic [q31nr_pkg::FRAC_W-1:0]     n_o,
  output logic signed [31:0]               x_o
);
  q31nr_pkg::ctl_t ctl_a_q, ctl_b_q;
  logic [q31nr_pkg::FRAC_W-1:0] d_a_q, n_a_q, d_b_q, n_b_q;
  logic signed [31:0] x_a_q, x_b_q;
  logic signed [30:0] d_s;
  logic signed [63:0] dx_d, dx_a_q, dx_rnd;
  logic signed [35:0] err;
  logic signed [67:0] xe_d, xe_b_q, xe_rnd;
  logic signed [39:0] x_sum;

  always_comb begin
    d_s = $signed({1'b0, d_i});
    dx_d = d_s * x_i;
    dx_rnd = (dx_a_q + q31nr_pkg::Q29_HALF) >>> 29;
    err = q31nr_pkg::Q29_ONE - dx_rnd[35:0];
    xe_d = x_a_q * err;
    xe_rnd = (xe_b_q + q31nr_pkg::Q29_HALF_W) >>> 29;
    x_sum = 40'(x_b_q) + xe_rnd[39:0];
    x_o = q31nr_pkg::sat32(x_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_a_q <= d_i;
      n_a_q <= n_i;
      x_a_q <= x_i;
      dx_a_q <= dx_d;
      d_b_q <= d_a_q;
      n_b_q <= n_a_q;
      x_b_q <= x_a_q;
      xe_b_q <= xe_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign d_o = d_b_q;
  assign n_o = n_b_q;
endmodule
`default_nettype wire

>>> rtl/q31nr_out.sv
// Final product N * X, rounding, saturation, sign and output register.
`default_nettype none
module q31nr_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire q31nr_pkg::ctl_t             ctl_i,
  input  wire logic [q31nr_pkg::FRAC_W-1:0] n_i,
  input  wire logic signed [31:0]          x_i,
  output logic                             valid_o,
  output logic signed [31:0]               quotient_o,
  output logic                             divide_by_zero_o,
  output logic                             saturated_o
);
  q31nr_pkg::ctl_t ctl_a_q, ctl_b_q;
  logic signed [30:0] n_s;
  logic signed [63:0] nx_d, nx_a_q, mag_rnd, mag;
  logic [31:0] q_d, q_q;
  logic dz_d, sat_d, dz_q, sat_q;

  always_comb begin
    n_s = $signed({1'b0, n_i});
    nx_d = n_s * x_i;
    mag_rnd = (nx_a_q + q31nr_pkg::OUT_ROUND) >>> 27;
    mag = (mag_rnd < 64'sd0) ? 64'sd0 : mag_rnd;
    dz_d = 1'b0;
    sat_d = 1'b0;
    if (ctl_a_q.zero) begin
      q_d = 32'd0;
      dz_d = 1'b1;
    end else if (ctl_a_q.big || (mag >= q31nr_pkg::MAG_LIMIT)) begin
      sat_d = 1'b1;
      q_d = ctl_a_q.neg ? q31nr_pkg::Q_NEG_MAX : q31nr_pkg::Q_POS_MAX;
    end else if (ctl_a_q.neg) begin
      q_d = ~mag[31:0] + 32'd1;
    end else begin
      q_d = mag[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_a_q <= nx_d;
      q_q <= q_d;
      dz_q <= dz_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o = ctl_b_q.valid;
  assign quotient_o = $signed(q_q);
  assign divide_by_zero_o = dz_q;
  assign saturated_o = sat_q;
endmodule
`default_nettype wire

>>> rtl/q31_newton_raphson_divider.sv
// Top level of the pipelined Q31 Newton-Raphson divider.
//
//   Channel  Role    Transfer carries
//   in_i     sink    numerator, denominator (signed Q31)
//   out_o    source  quotient (signed Q31), divide_by_zero, saturated
//
// One operand pair is taken every cycle unless the pipeline is stopped; a quotient
// passes the normalization, seed, two-stage refinement and output stages in turn.
// Reset clears the control bits (valid, zero, big and neg) of the stages, not the data.
// When the output register holds an untaken result the whole pipeline stops,
// and input ready is low for that cycle.
`default_nettype none
`include "q31_newton_raphson_divider_macros.svh"
module q31_newton_raphson_divider (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  q31nr_in_if.sink       in_i,
  q31nr_out_if.source    out_o
);
  localparam int STEPS = q31nr_pkg::NEWTON_STEPS;

  logic en;
  q31nr_pkg::ctl_t ctl_n, ctl_s;
  logic [q31nr_pkg::FRAC_W-1:0] d_n, n_n;
  q31nr_pkg::ctl_t ctl_k [STEPS+1];
  logic [q31nr_pkg::FRAC_W-1:0] d_k [STEPS+1];
  logic [q31nr_pkg::FRAC_W-1:0] n_k [STEPS+1];
  logic signed [31:0] x_k [STEPS+1];
  logic out_valid;

  assign en = !out_valid || out_o.ready;
  assign in_i.ready = en;

  q31nr_norm u_norm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_i.valid),
    .numerator_i   (in_i.numerator),
    .denominator_i (in_i.denominator),
    .ctl_o         (ctl_n),
    .d_o           (d_n),
    .n_o           (n_n)
  );

  q31nr_seed u_seed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_n),
    .d_i    (d_n),
    .n_i    (n_n),
    .ctl_o  (ctl_s),
    .d_o    (d_k[0]),
    .n_o    (n_k[0]),
    .x_o    (x_k[0])
  );
  assign ctl_k[0] = ctl_s;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    q31nr_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_k[g]),
      .d_i    (d_k[g]),
      .n_i    (n_k[g]),
      .x_i    (x_k[g]),
      .ctl_o  (ctl_k[g+1]),
      .d_o    (d_k[g+1]),
      .n_o    (n_k[g+1]),
      .x_o    (x_k[g+1])
    );
  end

  q31nr_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .ctl_i            (ctl_k[STEPS]),
    .n_i              (n_k[STEPS]),
    .x_i              (x_k[STEPS]),
    .valid_o          (out_valid),
    .quotient_o       (out_o.quotient),
    .divide_by_zero_o (out_o.divide_by_zero),
    .saturated_o      (out_o.saturated)
  );
  assign out_o.valid = out_valid;

  `Q31NR_ASSERT_IMP(a_dz_zero, out_o.valid && out_o.divide_by_zero, out_o.quotient == 32'sd0 && !out_o.saturated)
  `Q31NR_ASSERT_IMP(a_sat_clamp, out_o.valid && out_o.saturated, out_o.quotient == 32'sh7FFF_FFFF || out_o.quotient == 32'sh8000_0000)
  `Q31NR_ASSERT_NXT(a_stall_holds, !in_i.ready, out_o.valid)
endmodule
`default_nettype wire
